### src/lcg_pkg.sv
// lcg_pkg: shared types, constants and helper functions of the luma contrast gamma mapper
// used by lcg_front, lcg_queue, lcg_back and luma_contrast_gamma_mapper
// no dependencies
package lcg_pkg;

   // field widths
   localparam int SAMPLE_W   = 10;
   localparam int DEPTH_W    = 2;
   localparam int GAIN_W     = 11;
   localparam int BRIGHT_W   = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int PRODUCT_W  = GAIN_W + SAMPLE_W;

   // parameter defaults
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_BITS_DEF    = 10;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // reset values of the control registers
   localparam logic [GAIN_W-1:0] CONTRAST_RESET = 11'd255;

   // control register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_MODE        = 2'd0,
      CSR_CONTRAST_GAIN     = 2'd1,
      CSR_BRIGHTNESS_OFFSET = 2'd2,
      CSR_THRESHOLD_ENABLE  = 2'd3
   } csr_reg_type;

   // request kinds on the input channel
   typedef enum logic {
      REQ_MAP   = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

   // work kinds carried by the queue
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DIRECT = 2'd2
   } op_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]         depth_mode;
      logic [GAIN_W-1:0]          contrast_gain;
      logic signed [BRIGHT_W-1:0] brightness_offset;
      logic                       threshold_enable;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] addr;
      logic [SAMPLE_W-1:0] data;
   } entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // sample depth in bits, reserved mode acts as 10 bits, capped at max_bits
   function automatic logic [3:0] depth_bits(logic [DEPTH_W-1:0] mode, int max_bits);
      logic [3:0] d;
      begin
         d = (mode == 2'd3) ? 4'd10 : 4'd8 + {2'b00, mode};
         if (int'(d) > max_bits) begin
            d = 4'(max_bits);
         end
         return d;
      end
   endfunction

   // largest sample value at a depth of d bits
   function automatic logic [SAMPLE_W-1:0] max_value(logic [3:0] d);
      logic [SAMPLE_W:0] full_range;
      begin
         full_range = (SAMPLE_W+1)'(1) << d;
         return SAMPLE_W'(full_range - 1'b1);
      end
   endfunction

endpackage

### src/lcg_front.sv
// lcg_front: accepts request transactions, computes the gain product, then the table index
// or the threshold result, and pushes one work entry into the queue
// depends on lcg_pkg
module lcg_front
   import lcg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_BITS    = MAX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [SAMPLE_W-1:0] req_table_index,
   input  logic [SAMPLE_W-1:0] req_table_value,
   input  queue_status_type    q_status,
   output logic                q_push,
   output entry_type           q_push_entry
);

   localparam logic [SAMPLE_W-1:0] LastIndex = SAMPLE_W'(TABLE_DEPTH - 1);

   logic [3:0]          depth;
   logic [SAMPLE_W-1:0] maxv;
   logic [SAMPLE_W-1:0] midv;
   logic                accept;
   logic [SAMPLE_W-1:0] sample_sat;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_map_ff;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic [PRODUCT_W-1:0] s1_product_ff;
   logic [SAMPLE_W-1:0]  s1_index_ff;
   logic [SAMPLE_W-1:0]  s1_value_ff;

   logic [12:0]         shifted;
   logic signed [15:0]  lum;
   logic signed [15:0]  index_sum;
   logic [SAMPLE_W-1:0] index_clip;
   logic                below;

   // depth-derived constants; user keeps config stable while transactions are in flight
   assign depth = depth_bits(cfg.depth_mode, MAX_BITS);
   assign maxv  = max_value(depth);
   assign midv  = {1'b0, maxv[SAMPLE_W-1:1]} + 1'b1;

   // input handshake, stage one holds while the queue is full
   assign req_stall   = s1_valid_ff && q_status.full;
   assign accept      = req_valid && !req_stall;
   assign q_push      = s1_valid_ff && !q_status.full;
   assign s1_valid_in = accept || (s1_valid_ff && q_status.full);

   // saturate the sample to the depth
   assign sample_sat = (req_sample > maxv) ? maxv : req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage one: sample and gain product
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_map_ff     <= (req_type == REQ_MAP);
         s1_sample_ff  <= sample_sat;
         s1_product_ff <= cfg.contrast_gain * sample_sat;
         s1_index_ff   <= req_table_index;
         s1_value_ff   <= req_table_value;
      end
   end

   // table index: offset plus scaled product, clipped to the sample range and the table
   always_comb begin
      shifted   = 13'(s1_product_ff >> depth);
      lum       = 16'(cfg.brightness_offset) + $signed({6'b0, midv})
                - $signed({6'b0, cfg.contrast_gain[GAIN_W-1:1]});
      index_sum = lum + $signed({3'b0, shifted});
      if (index_sum < 0) begin
         index_clip = '0;
      end else if (index_sum > $signed({6'b0, maxv})) begin
         index_clip = maxv;
      end else begin
         index_clip = index_sum[SAMPLE_W-1:0];
      end
      if (index_clip > LastIndex) begin
         index_clip = LastIndex;
      end
   end

   // threshold compare against the signed brightness level
   assign below = $signed({2'b00, s1_sample_ff}) < $signed({cfg.brightness_offset[BRIGHT_W-1],
                                                            cfg.brightness_offset});

   // classify into a queue entry
   always_comb begin
      if (!s1_map_ff) begin
         q_push_entry.op   = OP_WRITE;
         q_push_entry.addr = s1_index_ff;
         q_push_entry.data = s1_value_ff;
      end else if (cfg.threshold_enable) begin
         q_push_entry.op   = OP_DIRECT;
         q_push_entry.addr = '0;
         q_push_entry.data = below ? '0 : maxv;
      end else begin
         q_push_entry.op   = OP_LOOKUP;
         q_push_entry.addr = index_clip;
         q_push_entry.data = '0;
      end
   end

endmodule

### src/lcg_queue.sv
// lcg_queue: short first-in first-out queue of work entries between front and back
// depends on lcg_pkg
module lcg_queue
   import lcg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

### src/lcg_back.sv
// lcg_back: pops work entries, writes or reads the gamma table memory and
// drives the registered result channel
// depends on lcg_pkg
module lcg_back
   import lcg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_BITS    = MAX_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  queue_status_type    q_status,
   input  entry_type           q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_luma_out
);

   localparam int AddrW = $clog2(TABLE_DEPTH);

   logic [SAMPLE_W-1:0] gamma_mem [TABLE_DEPTH];

   logic [SAMPLE_W-1:0] maxv;
   logic                b_free;
   logic                b_adv;
   logic                head_in_range;

   logic                b_valid_ff, b_valid_in;
   logic                b_direct_ff;
   logic [SAMPLE_W-1:0] b_data_ff;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [SAMPLE_W-1:0] b_result;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_luma_ff;

   assign maxv = max_value(depth_bits(cfg.depth_mode, MAX_BITS));

   // stage flow: lookup stage moves on when the output register is free or taken
   assign b_adv         = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_free        = !b_valid_ff || b_adv;
   assign q_pop         = !q_status.empty && b_free;
   assign head_in_range = int'(q_head.addr) < TABLE_DEPTH;

   assign b_valid_in   = (q_pop && (q_head.op != OP_WRITE)) || (b_valid_ff && !b_adv);
   assign rsp_valid_in = b_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // gamma table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (q_pop && (q_head.op == OP_WRITE) && head_in_range) begin
         gamma_mem[q_head.addr[AddrW-1:0]] <= q_head.data;
      end
      if (q_pop && (q_head.op == OP_LOOKUP)) begin
         rd_data_ff <= gamma_mem[q_head.addr[AddrW-1:0]];
      end
   end

   // lookup stage payload
   always_ff @(posedge clock) begin
      if (q_pop && (q_head.op != OP_WRITE)) begin
         b_direct_ff <= (q_head.op == OP_DIRECT);
         b_data_ff   <= q_head.data;
      end
   end

   // table value saturated to the depth, or the threshold result as is
   always_comb begin
      if (b_direct_ff) begin
         b_result = b_data_ff;
      end else if (rd_data_ff > maxv) begin
         b_result = maxv;
      end else begin
         b_result = rd_data_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_luma_ff <= b_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_luma_out = rsp_luma_ff;

endmodule

### src/luma_contrast_gamma_mapper.sv
// luma_contrast_gamma_mapper: top level with control registers, front, queue and back
// depends on lcg_pkg, lcg_front, lcg_queue, lcg_back
//
// Maps 8, 9 or 10 bit luma samples through brightness, contrast and a software-loaded
// gamma table, or to black or white in threshold mode. A request transaction either
// maps one sample (one result transaction) or writes one gamma table entry (no result).
// The block takes one request transaction per clock and returns one result per clock
// when neither side stalls. A mapped sample passes four registers (gain multiply, queue slot
// with the clipped index, table read, output register) before it is presented on the result
// channel, and it is taken when the receiver does not stall.
// Throughput is set by the back, which pops one queue entry per cycle while its lookup stage
// can move on, and serves a lookup on the single read port or a write on the single write port
// of the table memory. A four-entry queue between the front and the back lets request intake
// continue while a result is held by a stalled receiver.
// The gamma table is not cleared by reset: load every entry a lookup may reach
// before sending samples. Control registers may only be written while no transaction
// is in flight.
module luma_contrast_gamma_mapper
   import lcg_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_BITS    = MAX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [SAMPLE_W-1:0]   req_table_index,
   input  logic [SAMPLE_W-1:0]   req_table_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_luma_out
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   entry_type        q_push_entry;
   entry_type        q_head;
   logic             q_push;
   logic             q_pop;

   // control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:        cfg_in.depth_mode        = csr_write_data[DEPTH_W-1:0];
            CSR_CONTRAST_GAIN:     cfg_in.contrast_gain     = csr_write_data[GAIN_W-1:0];
            CSR_BRIGHTNESS_OFFSET: cfg_in.brightness_offset = $signed(csr_write_data[BRIGHT_W-1:0]);
            CSR_THRESHOLD_ENABLE:  cfg_in.threshold_enable  = csr_write_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode        <= '0;
         cfg_ff.contrast_gain     <= CONTRAST_RESET;
         cfg_ff.brightness_offset <= '0;
         cfg_ff.threshold_enable  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: intake, product and classification
   lcg_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_BITS    (MAX_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_sample      (req_sample),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_push_entry    (q_push_entry)
   );

   // queue between front and back
   lcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // back: table memory and result channel
   lcg_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_BITS    (MAX_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_status     (q_status),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_luma_out (rsp_luma_out)
   );

`ifndef SYNTH
   // queue fill never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   // intake only stalls on a full queue
   a_stall_on_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_status.full)
      else $error("request stalled while queue has room");

   // back never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // a lone push grows the fill count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> q_status.count == QCNT_W'($past(q_status.count) + 1'b1))
      else $error("queue fill count did not track a push");
`endif

endmodule
